/* hdl/crra_pkg.sv */
// ----------------------------------------------------------------------------
// crra_pkg
// shared types and constants for the clock ratio rational approximation block
// ----------------------------------------------------------------------------
`default_nettype none

package crra_pkg;

  // default parameter values
  localparam int MAX_ROUNDS_DEF    = 15;
  localparam int FRACTION_BITS_DEF = 32;

  // fixed field widths
  localparam int RATIO_W = 48;
  localparam int OUT_W   = 32;

  // tolerance register reset, about 0.00005 at 32 fraction bits
  localparam logic [31:0] TOL_RESET = 32'd214748;

  // register word index of the tolerance register
  localparam logic REG_TOL = 1'b0;

  // datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_TOL,
    OP_DIV_INIT,
    OP_MUL_DEN,
    OP_MUL_NUM,
    OP_STEP,
    OP_ROUND,
    OP_OUT
  } crra_op_t;

  // datapath status toward the controller
  typedef struct packed {
    logic tol_met;
    logic rem_zero;
  } crra_stat_t;

endpackage

`default_nettype wire

/* hdl/crra_if.sv */
// ----------------------------------------------------------------------------
// crra channel interfaces
// valid/ready channels carrying the ratio beat and the result beat
// ----------------------------------------------------------------------------
`default_nettype none

interface crra_in_if;
  logic                         valid;
  logic                         ready;
  logic [crra_pkg::RATIO_W-1:0] ratio_value;

  modport source (output valid, output ratio_value, input ready);
  modport sink (input valid, input ratio_value, output ready);
endinterface

interface crra_out_if;
  logic                       valid;
  logic                       ready;
  logic [crra_pkg::OUT_W-1:0] numerator;
  logic [crra_pkg::OUT_W-1:0] denominator;
  logic                       converged;
  logic                       overflow;

  modport source (output valid, output numerator, output denominator,
                  output converged, output overflow, input ready);
  modport sink (input valid, input numerator, input denominator,
                input converged, input overflow, output ready);
endinterface

`default_nettype wire

/* hdl/crra_datapath.sv */
// ----------------------------------------------------------------------------
// crra_datapath
// continued fraction registers, bit-serial multiplier, restoring divider
// ----------------------------------------------------------------------------
`default_nettype none

module crra_datapath #(
  parameter int FRACTION_BITS = crra_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire crra_pkg::crra_op_t           op,
  input  wire logic [crra_pkg::RATIO_W-1:0] ratio_value,
  input  wire logic [31:0]                  tol,
  output crra_pkg::crra_stat_t              stat,
  output logic [crra_pkg::OUT_W-1:0]        numerator,
  output logic [crra_pkg::OUT_W-1:0]        denominator,
  output logic                              converged,
  output logic                              overflow
);

  localparam int F  = FRACTION_BITS;
  localparam int D  = F + 1;                  // q, r, d, quotient width
  localparam int XW = crra_pkg::RATIO_W;
  localparam int W  = XW + D;                 // product width
  localparam int NW = W - F;                  // numerator width

  logic [XW-1:0] x_r;
  logic [D-1:0]  q_r, r_r, d_r, dp_r, err_r;
  logic [NW-1:0] n_r;
  logic [W-1:0]  acc_r, mcand_r;
  logic [D-1:0]  mplier_r;
  logic [D:0]    drem_r;
  logic [D-1:0]  dquo_r;

  logic [crra_pkg::OUT_W-1:0] num_o_r, den_o_r;
  logic                       conv_o_r, ovf_o_r;

  // divider step
  logic [D:0]    div_sh;
  logic          div_ge;
  // rounding of x*d
  logic [F-1:0]  frac;
  logic [D-1:0]  err_up;
  // saturation
  logic [63:0]   n64, d64;
  logic          ovf_n, ovf_d;

  always_comb begin
    div_sh = {drem_r[D-1:0], dquo_r[D-1]};
    div_ge = (div_sh >= {1'b0, r_r});
    frac   = acc_r[F-1:0];
    err_up = {1'b1, {F{1'b0}}} - {1'b0, frac};
    n64    = 64'(n_r);
    d64    = 64'(d_r);
    ovf_n  = |n64[63:32];
    ovf_d  = |d64[63:32];
  end

  // err/d < tol is the same as err < tol*d
  assign stat.tol_met  = (W'(err_r) < acc_r);
  assign stat.rem_zero = (r_r == '0);

  always_ff @(posedge clk) begin
    case (op)
      crra_pkg::OP_LOAD: begin
        x_r   <= ratio_value;
        q_r   <= {1'b1, {F{1'b0}}};
        r_r   <= D'(ratio_value[F-1:0]);
        err_r <= D'(ratio_value[F-1:0]);
        d_r   <= D'(1);
        dp_r  <= '0;
        n_r   <= NW'(ratio_value >> F);
      end
      crra_pkg::OP_MUL_TOL: begin
        acc_r    <= '0;
        mcand_r  <= W'(tol);
        mplier_r <= d_r;
      end
      crra_pkg::OP_DIV_INIT: begin
        drem_r <= '0;
        dquo_r <= q_r;
      end
      crra_pkg::OP_MUL_DEN: begin
        // commit the euclid step, then start d*a + d_prev
        q_r      <= r_r;
        r_r      <= drem_r[D-1:0];
        acc_r    <= W'(dp_r);
        mcand_r  <= W'(dquo_r);
        mplier_r <= d_r;
      end
      crra_pkg::OP_MUL_NUM: begin
        dp_r     <= d_r;
        d_r      <= acc_r[D-1:0];
        acc_r    <= '0;
        mcand_r  <= W'(x_r);
        mplier_r <= acc_r[D-1:0];
      end
      crra_pkg::OP_STEP: begin
        // one multiplier bit and one quotient bit
        acc_r    <= acc_r + (mplier_r[0] ? mcand_r : '0);
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
        drem_r   <= div_ge ? (div_sh - {1'b0, r_r}) : div_sh;
        dquo_r   <= {dquo_r[D-2:0], div_ge};
      end
      crra_pkg::OP_ROUND: begin
        // round half up
        n_r   <= acc_r[W-1:F] + NW'(frac[F-1]);
        err_r <= frac[F-1] ? err_up : D'(frac);
      end
      crra_pkg::OP_OUT: begin
        num_o_r  <= ovf_n ? '1 : n64[31:0];
        den_o_r  <= ovf_d ? '1 : d64[31:0];
        conv_o_r <= stat.tol_met;
        ovf_o_r  <= ovf_n | ovf_d;
      end
      default: begin
      end
    endcase
  end

  assign numerator   = num_o_r;
  assign denominator = den_o_r;
  assign converged   = conv_o_r;
  assign overflow    = ovf_o_r;

endmodule

`default_nettype wire

/* hdl/crra_ctrl.sv */
// ----------------------------------------------------------------------------
// crra_ctrl
// round sequencer: tolerance check, divide, denominator and numerator update
// ----------------------------------------------------------------------------
`default_nettype none

module crra_ctrl #(
  parameter int MAX_ROUNDS    = crra_pkg::MAX_ROUNDS_DEF,
  parameter int FRACTION_BITS = crra_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire crra_pkg::crra_stat_t stat,
  output crra_pkg::crra_op_t        op
);

  localparam int D  = FRACTION_BITS + 1;
  localparam int CW = $clog2(D);
  localparam int RW = $clog2(MAX_ROUNDS);

  typedef enum logic [3:0] {
    S_IDLE, S_TOL, S_CHECK, S_DEN, S_NUM, S_RND, S_RUN, S_DONE
  } state_t;

  state_t          state_r, ret_r;
  logic [CW-1:0]   cnt_r;
  logic [RW-1:0]   round_r;
  logic            out_valid_r;
  logic            stop;
  logic            emit;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign stop      = stat.tol_met || stat.rem_zero || (round_r == RW'(MAX_ROUNDS - 1));
  assign emit      = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // command decode
  always_comb begin
    op = crra_pkg::OP_NONE;
    case (state_r)
      S_IDLE:  op = in_valid ? crra_pkg::OP_LOAD : crra_pkg::OP_NONE;
      S_TOL:   op = crra_pkg::OP_MUL_TOL;
      S_CHECK: op = stop ? crra_pkg::OP_NONE : crra_pkg::OP_DIV_INIT;
      S_DEN:   op = crra_pkg::OP_MUL_DEN;
      S_NUM:   op = crra_pkg::OP_MUL_NUM;
      S_RND:   op = crra_pkg::OP_ROUND;
      S_RUN:   op = crra_pkg::OP_STEP;
      S_DONE:  op = emit ? crra_pkg::OP_OUT : crra_pkg::OP_NONE;
      default: op = crra_pkg::OP_NONE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      cnt_r       <= '0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result beat: raised on emit, dropped once taken
      out_valid_r <= emit || (out_valid_r && !out_ready);
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            round_r <= RW'(1);
            state_r <= S_TOL;
          end
        end
        S_TOL: begin
          cnt_r   <= '0;
          ret_r   <= S_CHECK;
          state_r <= S_RUN;
        end
        S_CHECK: begin
          if (stop) begin
            state_r <= S_DONE;
          end else begin
            cnt_r   <= '0;
            ret_r   <= S_DEN;
            state_r <= S_RUN;
          end
        end
        S_DEN: begin
          cnt_r   <= '0;
          ret_r   <= S_NUM;
          state_r <= S_RUN;
        end
        S_NUM: begin
          cnt_r   <= '0;
          ret_r   <= S_RND;
          state_r <= S_RUN;
        end
        S_RND: begin
          round_r <= round_r + RW'(1);
          state_r <= S_TOL;
        end
        S_RUN: begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(D - 1)) begin
            state_r <= ret_r;
          end
        end
        S_DONE: begin
          if (emit) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/clock_ratio_rational_approx.sv */
// ----------------------------------------------------------------------------
// clock_ratio_rational_approx
// continued-fraction numerator/denominator pair for a fixed-point clock ratio
// ----------------------------------------------------------------------------
// One ratio beat (unsigned, FRACTION_BITS fraction bits) yields one result
// beat with numerator and denominator saturated to 32 bits, a converged flag
// and an overflow flag. Items are handled one at a time. Each round uses one
// shared bit-serial multiplier and restoring divider. The result beat is
// offered once the first tolerance check finds that the integer part
// already meets the tolerance, and after at most MAX_ROUNDS-2 rounds in the
// worst case. A finished result waits in an output register while the next
// ratio is accepted.
// error_tolerance sits at byte address 0.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_ratio_rational_approx #(
  parameter int MAX_ROUNDS    = crra_pkg::MAX_ROUNDS_DEF,
  parameter int FRACTION_BITS = crra_pkg::FRACTION_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  crra_in_if.sink          in_ch,
  crra_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [31:0]          tol_r;
  crra_pkg::crra_op_t   op;
  crra_pkg::crra_stat_t stat;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == crra_pkg::REG_TOL) ? tol_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= crra_pkg::TOL_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == crra_pkg::REG_TOL) begin
      tol_r <= cfg_pwdata;
    end
  end

  // sequencer
  crra_ctrl #(
    .MAX_ROUNDS    (MAX_ROUNDS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .op        (op)
  );

  // arithmetic
  crra_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk         (clk),
    .op          (op),
    .ratio_value (in_ch.ratio_value),
    .tol         (tol_r),
    .stat        (stat),
    .numerator   (out_ch.numerator),
    .denominator (out_ch.denominator),
    .converged   (out_ch.converged),
    .overflow    (out_ch.overflow)
  );

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// testbench for the clock ratio rational approximation block
// ----------------------------------------------------------------------------
// Ratio beats go in with bursty valid and come back against a stalling
// ready. Every result is compared with a typed value for the obvious directed
// rows, else with a continued-fraction predictor kept in the testbench. The
// tolerance register is swept through several values, the extremes among
// them, and it is only written while the block is idle.
`default_nettype none

module tb_top;

  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [crra_pkg::OUT_W-1:0] numerator;
    logic [crra_pkg::OUT_W-1:0] denominator;
    logic                       converged;
    logic                       overflow;
  } fraction_t;

  typedef struct {
    logic [crra_pkg::RATIO_W-1:0] ratio;
    bit                           typed;
    fraction_t                    result;
  } ratio_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  crra_in_if  in_ch ();
  crra_out_if out_ch ();

  clock_ratio_rational_approx dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  fraction_t   pending_fractions[$];
  logic [31:0] tolerance;
  int          fail_count;
  int          idle_cycles;
  int          ratios_sent;
  int          fractions_seen;
  int          converged_seen;
  int          overflow_seen;
  int          burst_left;
  int          stall_mode;
  int          stall_left;
  ratio_row_t  directed_rows[$];

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // continued-fraction expansion with exact integer arithmetic
  function automatic fraction_t approx_ratio(input logic [crra_pkg::RATIO_W-1:0] x,
                                             input logic [31:0] tol);
    logic [63:0]  q, r, d_prev, d, n, err, a, t, d_next, x64;
    logic [127:0] prod;
    logic [31:0]  rem;
    bit           stop;
    fraction_t    f;
    q      = 64'h1_0000_0000;
    r      = {32'd0, x[31:0]};
    d_prev = 64'd0;
    d      = 64'd1;
    n      = {48'd0, x[47:32]};
    err    = r;
    stop   = 1'b0;
    x64    = {16'd0, x};
    for (int k = 1; k < crra_pkg::MAX_ROUNDS_DEF - 1; k++) begin
      if (!stop) begin
        if ((err / d) < {32'd0, tol} || r == 64'd0) begin
          stop = 1'b1;
        end else begin
          a      = q / r;
          t      = q % r;
          q      = r;
          r      = t;
          d_next = d * a + d_prev;
          d_prev = d;
          d      = d_next;
          prod   = {64'd0, x64} * {64'd0, d};
          rem    = prod[31:0];
          // round half up
          if (rem[31]) begin
            n   = prod[95:32] + 64'd1;
            err = 64'h1_0000_0000 - {32'd0, rem};
          end else begin
            n   = prod[95:32];
            err = {32'd0, rem};
          end
        end
      end
    end
    f.overflow    = (n > 64'hFFFF_FFFF) || (d > 64'hFFFF_FFFF);
    f.numerator   = (n > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n[31:0];
    f.denominator = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
    f.converged   = (err / d) < {32'd0, tol};
    return f;
  endfunction

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    fraction_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_mode   <= 0;
      stall_left   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.numerator, out_ch.denominator, out_ch.converged,
                out_ch.overflow};
        fractions_seen <= fractions_seen + 1;
        if (got.converged) converged_seen <= converged_seen + 1;
        if (got.overflow) overflow_seen <= overflow_seen + 1;
        if (pending_fractions.size() == 0) begin
          $display("%0t: unexpected result beat n=%h d=%h c=%b o=%b", $time,
                   got.numerator, got.denominator, got.converged, got.overflow);
          fail_count++;
        end else begin
          want = pending_fractions.pop_front();
          if (got.numerator !== want.numerator) begin
            $display("%0t: numerator expected %h actual %h", $time,
                     want.numerator, got.numerator);
            fail_count++;
          end
          if (got.denominator !== want.denominator) begin
            $display("%0t: denominator expected %h actual %h", $time,
                     want.denominator, got.denominator);
            fail_count++;
          end
          if (got.converged !== want.converged) begin
            $display("%0t: converged expected %b actual %b", $time,
                     want.converged, got.converged);
            fail_count++;
          end
          if (got.overflow !== want.overflow) begin
            $display("%0t: overflow expected %b actual %b", $time,
                     want.overflow, got.overflow);
            fail_count++;
          end
        end
      end
      // pick a new stall mode now and then: always ready, light, heavy
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(20, 300);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 pending_fractions.size());
        $display("clock_ratio_rational_approx test failed");
        $finish;
      end
    end
  end

  // register access, setup then access cycle; returns read data
  task automatic reg_access(input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {crra_pkg::REG_TOL, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // write the tolerance and read it back
  task automatic set_tolerance(input logic [31:0] value);
    logic [31:0] rd;
    reg_access(1'b1, value, rd);
    tolerance = value;
    reg_access(1'b0, 32'd0, rd);
    if (rd !== value) begin
      $display("%0t: tolerance readback expected %h actual %h", $time, value, rd);
      fail_count++;
    end
  endtask

  // let every outstanding result come back
  task automatic drain;
    while (pending_fractions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // send one ratio beat, bursts separated by random gaps
  task automatic send_ratio(input logic [crra_pkg::RATIO_W-1:0] ratio,
                            input bit typed, input fraction_t typed_result);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 6);
    end
    in_ch.valid       <= 1'b1;
    in_ch.ratio_value <= ratio;
    do @(posedge clk); while (!in_ch.ready);
    pending_fractions.push_back(typed ? typed_result
                                      : approx_ratio(ratio, tolerance));
    ratios_sent++;
    burst_left--;
  endtask

  task automatic end_stimulus;
    in_ch.valid <= 1'b0;
    burst_left = 0;
    drain();
  endtask

  // random ratio: mostly random bits, some small rationals and near-integers
  function automatic logic [crra_pkg::RATIO_W-1:0] random_ratio;
    logic [63:0] p, q;
    case ($urandom_range(0, 4))
      0: return {16'($urandom_range(0, 65535)), $urandom()};
      1: return {16'd0, $urandom()};
      2: begin
        // small rational p/q in fixed point
        q = $urandom_range(1, 1000);
        p = $urandom_range(0, 5000);
        p = (p << 32) / q;
        return p[crra_pkg::RATIO_W-1:0];
      end
      3: begin
        // near an integer
        return {16'($urandom_range(0, 65535)), ($urandom_range(0, 1) != 0) ?
                32'(0 - $urandom_range(0, 255)) : 32'($urandom_range(0, 255))};
      end
      default: return {16'($urandom_range(1, 16)), $urandom()};
    endcase
  endfunction

  initial begin
    logic [31:0] rd;
    fraction_t   none;
    logic [31:0] tol_steps[5];
    none           = '0;
    tolerance      = crra_pkg::TOL_RESET;
    fail_count     = 0;
    ratios_sent    = 0;
    fractions_seen = 0;
    converged_seen = 0;
    overflow_seen  = 0;
    burst_left     = 0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.ratio_value = '0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;

    // directed rows: typed results only where obvious
    directed_rows = '{
      '{48'h0000_0000_0000, 1'b1, '{32'd0, 32'd1, 1'b1, 1'b0}},
      '{48'h0001_0000_0000, 1'b1, '{32'd1, 32'd1, 1'b1, 1'b0}},
      '{48'h0000_8000_0000, 1'b1, '{32'd1, 32'd2, 1'b1, 1'b0}},
      '{48'hFFFF_0000_0000, 1'b1, '{32'd65535, 32'd1, 1'b1, 1'b0}},
      '{48'hFFFF_FFFF_FFFF, 1'b0, none},
      '{48'h0000_0000_0001, 1'b0, none},
      '{48'h0000_FFFF_FFFF, 1'b0, none},
      '{48'h0001_0000_0001, 1'b0, none},
      '{48'h0000_5555_5555, 1'b0, none},
      '{48'h0003_243F_6A88, 1'b0, none},
      '{48'h0002_B7E1_5162, 1'b0, none},
      '{48'h0001_6A09_E667, 1'b0, none},
      '{48'hAAAA_AAAA_AAAA, 1'b0, none},
      '{48'h5555_5555_5555, 1'b0, none},
      '{48'h0000_0000_8000, 1'b0, none}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register comes out of reset at its default
    reg_access(1'b0, 32'd0, rd);
    if (rd !== crra_pkg::TOL_RESET) begin
      $display("%0t: tolerance after reset expected %h actual %h", $time,
               crra_pkg::TOL_RESET, rd);
      fail_count++;
    end

    foreach (directed_rows[i])
      send_ratio(directed_rows[i].ratio, directed_rows[i].typed,
                 directed_rows[i].result);
    end_stimulus();

    // zero tolerance: never converged, rounds run until remainder zero or the limit
    set_tolerance(32'd0);
    send_ratio(48'h0000_5555_5555, 1'b1, '{32'd0, 32'd0, 1'b0, 1'b0});
    pending_fractions[pending_fractions.size() - 1] =
      approx_ratio(48'h0000_5555_5555, 32'd0);
    send_ratio(48'hFFFF_FFFF_FFFF, 1'b0, none);
    send_ratio(48'h0000_0000_0000, 1'b1, '{32'd0, 32'd1, 1'b0, 1'b0});
    end_stimulus();

    // random phases across tolerance settings
    tol_steps = '{32'd1, 32'hFFFF_FFFF, 32'd0, crra_pkg::TOL_RESET, $urandom()};
    foreach (tol_steps[s]) begin
      set_tolerance(tol_steps[s]);
      repeat (160) send_ratio(random_ratio(), 1'b0, none);
      end_stimulus();
    end

    $display("sent %0d ratios over 7 tolerance settings, %0d results checked",
             ratios_sent, fractions_seen);
    $display("%0d results converged, %0d saturated", converged_seen,
             overflow_seen);
    if (fail_count == 0 && pending_fractions.size() == 0) begin
      $display("clock_ratio_rational_approx test passed");
    end else begin
      $display("clock_ratio_rational_approx test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hdl/crra_pkg.sv
hdl/crra_if.sv
hdl/crra_datapath.sv
hdl/crra_ctrl.sv
hdl/clock_ratio_rational_approx.sv
test/tb_top.sv
